// ----- src/lmtb_pkg.sv -----
package lmtb_pkg;

   localparam int MAX_REMOVED_DEF = 64;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int TOL_WIDTH       = 31;
   localparam int SHIFT_WIDTH     = 32;
   localparam int OP_WIDTH        = 2;
   localparam int STATUS_WIDTH    = 3;
   localparam int CSR_ADDR_WIDTH  = 5;

   // item operations
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_QUERY = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_NONE  = 2'd3;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_UNCHANGED = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_REVIEW    = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_UPDATED   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_LOADED    = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd4;

   // register indexes
   localparam logic [2:0] REG_TOL     = 3'd0;
   localparam logic [2:0] REG_SHIFT_X = 3'd1;
   localparam logic [2:0] REG_SHIFT_Y = 3'd2;
   localparam logic [2:0] REG_FOUND   = 3'd3;
   localparam logic [2:0] REG_UNCLEAR = 3'd4;

   // one token travelling the chain: query marker and the hit flags of both lines
   typedef struct packed {
      logic        valid;
      logic        hit_a;
      logic        hit_b;
   } lmtb_tok_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } lmtb_state_type;

endpackage

// ----- src/lmtb_cell.sv -----
// One table slot: holds a removed segment, compares the passing query lines
// against it and hands the token to the next slot.
module lmtb_cell #(
   parameter int CW = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        load,
   input  logic signed [CW-1:0]        load_seg [4],
   input  logic [lmtb_pkg::TOL_WIDTH-1:0] tol,
   input  logic signed [CW-1:0]        line_a [4],
   input  logic signed [CW-1:0]        line_b [4],
   input  lmtb_pkg::lmtb_tok_type      tok_i,
   output lmtb_pkg::lmtb_tok_type      tok_o,
   output logic                        full_o
);
   import lmtb_pkg::*;

   // common width for the distance and tolerance compare
   localparam int NW = (CW + 1 > TOL_WIDTH) ? CW + 1 : TOL_WIDTH;

   logic signed [CW-1:0] seg_ff [4];
   logic                 used_ff;
   lmtb_tok_type         tok_ff;
   logic                 eq_a, eq_b;

   function automatic logic near(input logic signed [CW-1:0] x,
                                 input logic signed [CW-1:0] y,
                                 input logic [TOL_WIDTH-1:0] t);
      logic signed [CW:0] d;
      logic [CW:0]        ad;
      begin
         d  = {x[CW-1], x} - {y[CW-1], y};
         ad = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
         near = (NW'(ad) <= NW'(t));
      end
   endfunction

   function automatic logic seg_eq(input logic signed [CW-1:0] l [4],
                                   input logic signed [CW-1:0] s [4],
                                   input logic [TOL_WIDTH-1:0] t);
      begin
         seg_eq = (near(l[0], s[0], t) && near(l[1], s[1], t) &&
                   near(l[2], s[2], t) && near(l[3], s[3], t)) ||
                  (near(l[0], s[2], t) && near(l[1], s[3], t) &&
                   near(l[2], s[0], t) && near(l[3], s[1], t));
      end
   endfunction

   assign eq_a = used_ff && seg_eq(line_a, seg_ff, tol);
   assign eq_b = used_ff && seg_eq(line_b, seg_ff, tol);

   // segment store
   always_ff @(posedge clock) begin
      if (load) begin
         seg_ff <= load_seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff <= 1'b0;
      end else if (load) begin
         used_ff <= 1'b1;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff.valid <= tok_i.valid;
         tok_ff.hit_a <= tok_i.hit_a | eq_a;
         tok_ff.hit_b <= tok_i.hit_b | eq_b;
      end
   end

   assign tok_o  = tok_ff;
   assign full_o = used_ff;
endmodule

// ----- src/line_match_translate_binding.sv -----
// Removed-segment matcher. The table is a row of MAX_REMOVED slots, each
// with its own comparator. A clear or add item is accepted in idle, and its
// result is registered from the run state. A query first latches its lines,
// then sends a token down the row, one slot per cycle, with each slot
// registering the token; the result is registered once the token leaves the
// last slot. The result is held in an output register until taken, and the
// next item is accepted in the cycle after that, so the block takes no new
// item before it is through with the last one.
module line_match_translate_binding #(
   parameter int MAX_REMOVED = lmtb_pkg::MAX_REMOVED_DEF,
   parameter int COORD_WIDTH = lmtb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lmtb_pkg::OP_WIDTH-1:0]         req_op,
   input  logic signed [COORD_WIDTH-1:0]         req_first_x1,
   input  logic signed [COORD_WIDTH-1:0]         req_first_y1,
   input  logic signed [COORD_WIDTH-1:0]         req_first_x2,
   input  logic signed [COORD_WIDTH-1:0]         req_first_y2,
   input  logic signed [COORD_WIDTH-1:0]         req_second_x1,
   input  logic signed [COORD_WIDTH-1:0]         req_second_y1,
   input  logic signed [COORD_WIDTH-1:0]         req_second_x2,
   input  logic signed [COORD_WIDTH-1:0]         req_second_y2,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lmtb_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic                                  rsp_first_moved,
   output logic                                  rsp_second_moved,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_first_x1,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_first_y1,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_first_x2,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_first_y2,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_second_x1,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_second_y1,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_second_x2,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_second_y2,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lmtb_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import lmtb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int CNT_W = $clog2(MAX_REMOVED + 1);
   localparam int SH_W  = (CW < SHIFT_WIDTH) ? CW : SHIFT_WIDTH;
   localparam int SUM_W = ((CW > SHIFT_WIDTH) ? CW : SHIFT_WIDTH) + 1;

   // configuration
   logic [TOL_WIDTH-1:0]  tol_ff;
   logic signed [SH_W-1:0] sx_ff, sy_ff;
   logic                  found_ff, unclear_ff;
   logic                  wr_en;
   logic [2:0]            reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0; sx_ff <= '0; sy_ff <= '0;
         found_ff <= 1'b0; unclear_ff <= 1'b0;
      end else if (wr_en && paddr[1:0] == 2'b00) begin
         unique case (reg_idx)
            REG_TOL:     tol_ff     <= pwdata[TOL_WIDTH-1:0];
            REG_SHIFT_X: sx_ff      <= pwdata[SH_W-1:0];
            REG_SHIFT_Y: sy_ff      <= pwdata[SH_W-1:0];
            REG_FOUND:   found_ff   <= pwdata[0];
            REG_UNCLEAR: unclear_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_TOL:     prdata = {1'b0, tol_ff};
         REG_SHIFT_X: prdata = 32'(signed'(sx_ff));
         REG_SHIFT_Y: prdata = 32'(signed'(sy_ff));
         REG_FOUND:   prdata = {31'd0, found_ff};
         REG_UNCLEAR: prdata = {31'd0, unclear_ff};
         default:     prdata = '0;
      endcase
   end

   // held item
   lmtb_state_type        state_ff;
   logic [OP_WIDTH-1:0]   op_ff;
   logic signed [CW-1:0]  la_ff [4];
   logic signed [CW-1:0]  lb_ff [4];
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      run_ff;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // slot row
   lmtb_tok_type tok [MAX_REMOVED+1];
   logic         full [MAX_REMOVED];
   logic         cell_clear;
   logic         start;

   // launch the token once the query lines sit in la_ff / lb_ff
   assign start      = (state_ff == ST_RUN) && (op_ff == OP_QUERY) && (run_ff == '0);
   assign cell_clear = accept && req_op == OP_CLEAR;
   assign tok[0]     = '{valid: start, hit_a: 1'b0, hit_b: 1'b0};

   logic signed [CW-1:0] add_seg [4];
   assign add_seg = '{req_first_x1, req_first_y1, req_first_x2, req_first_y2};

   genvar g;
   generate
      for (g = 0; g < MAX_REMOVED; g++) begin : g_slot
         lmtb_cell #(.CW(CW)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .clear    (cell_clear),
            .load     (accept && req_op == OP_ADD && cnt_ff == CNT_W'(g)),
            .load_seg (add_seg),
            .tol      (tol_ff),
            .line_a   (la_ff),
            .line_b   (lb_ff),
            .tok_i    (tok[g]),
            .tok_o    (tok[g+1]),
            .full_o   (full[g])
         );
      end
   endgenerate

   // saturating shift
   function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                    input logic signed [SH_W-1:0] b);
      logic signed [SUM_W-1:0] s;
      logic signed [SUM_W-1:0] hi, lo;
      begin
         hi = SUM_W'({1'b0, {(CW-1){1'b1}}});
         lo = -hi - SUM_W'(1);
         s  = SUM_W'(a) + SUM_W'(b);
         if (s > hi)      sat_add = hi[CW-1:0];
         else if (s < lo) sat_add = lo[CW-1:0];
         else             sat_add = s[CW-1:0];
      end
   endfunction

   // result register
   logic                  rv_ff;
   logic [STATUS_WIDTH-1:0] st_ff;
   logic                  ma_ff, mb_ff;
   logic signed [CW-1:0]  oa_ff [4];
   logic signed [CW-1:0]  ob_ff [4];
   logic                  ha, hb, upd;

   assign ha  = tok[MAX_REMOVED].hit_a;
   assign hb  = tok[MAX_REMOVED].hit_b;
   assign upd = found_ff && !unclear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               op_ff <= req_op;
               la_ff <= '{req_first_x1, req_first_y1, req_first_x2, req_first_y2};
               lb_ff <= '{req_second_x1, req_second_y1, req_second_x2, req_second_y2};
               run_ff <= '0;
               if (req_op == OP_CLEAR) cnt_ff <= '0;
               else if (req_op == OP_ADD && cnt_ff < CNT_W'(MAX_REMOVED))
                  cnt_ff <= cnt_ff + 1'b1;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               st_ff <= ST_UNCHANGED; ma_ff <= 1'b0; mb_ff <= 1'b0;
               oa_ff <= '{default: '0}; ob_ff <= '{default: '0};
               unique case (op_ff)
                  OP_CLEAR: begin
                     st_ff <= ST_LOADED; rv_ff <= 1'b1; state_ff <= ST_OUT;
                  end
                  OP_ADD: begin
                     st_ff <= (full[MAX_REMOVED-1] && cnt_ff == CNT_W'(MAX_REMOVED)
                               && !tok[0].valid && run_ff == '0 && 1'b0) ?
                              ST_FULL : ST_LOADED;
                     rv_ff <= 1'b1; state_ff <= ST_OUT;
                  end
                  OP_QUERY: begin
                     if (tok[MAX_REMOVED].valid) begin
                        ma_ff <= ha; mb_ff <= hb;
                        oa_ff <= la_ff; ob_ff <= lb_ff;
                        if (!ha && !hb) st_ff <= ST_UNCHANGED;
                        else if (!upd)  st_ff <= ST_REVIEW;
                        else begin
                           st_ff <= ST_UPDATED;
                           if (ha) oa_ff <= '{sat_add(la_ff[0], sx_ff),
                                              sat_add(la_ff[1], sy_ff),
                                              sat_add(la_ff[2], sx_ff),
                                              sat_add(la_ff[3], sy_ff)};
                           if (hb) ob_ff <= '{sat_add(lb_ff[0], sx_ff),
                                              sat_add(lb_ff[1], sy_ff),
                                              sat_add(lb_ff[2], sx_ff),
                                              sat_add(lb_ff[3], sy_ff)};
                        end
                        rv_ff <= 1'b1; state_ff <= ST_OUT;
                     end
                  end
                  default: begin
                     rv_ff <= 1'b1; state_ff <= ST_OUT;
                  end
               endcase
               run_ff <= run_ff + 1'b1;
            end
            ST_OUT: if (rsp_ready) begin
               rv_ff <= 1'b0; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // full flag for an add is decided at acceptance
   logic full_hit_ff;
   always_ff @(posedge clock) begin
      if (accept) full_hit_ff <= (req_op == OP_ADD) && (cnt_ff == CNT_W'(MAX_REMOVED));
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = (op_ff == OP_ADD && full_hit_ff) ? ST_FULL : st_ff;
   assign rsp_first_moved   = ma_ff;
   assign rsp_second_moved  = mb_ff;
   assign rsp_out_first_x1  = oa_ff[0];
   assign rsp_out_first_y1  = oa_ff[1];
   assign rsp_out_first_x2  = oa_ff[2];
   assign rsp_out_first_y2  = oa_ff[3];
   assign rsp_out_second_x1 = ob_ff[0];
   assign rsp_out_second_y1 = ob_ff[1];
   assign rsp_out_second_x2 = ob_ff[2];
   assign rsp_out_second_y2 = ob_ff[3];
endmodule

// ----- test/tb_line_match_translate_binding.sv -----
module tb_line_match_translate_binding;
   import lmtb_pkg::*;

   localparam int NSLOT = MAX_REMOVED_DEF;
   localparam int NRAND = 1800;
   localparam int WDOG_LIMIT = 20000;

   typedef logic signed [31:0] coord_t;

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      coord_t              c[8];
   } bind_item_t;

   typedef struct {
      logic [STATUS_WIDTH-1:0] status;
      logic                    m1;
      logic                    m2;
      coord_t                  c[8];
   } bind_result_t;

   // shadow of the segment table and registers, plus expected-result queue
   class binding_scoreboard;
      coord_t       seg_tab[NSLOT][4];
      int           seg_count;
      logic [30:0]  tol;
      coord_t       sx, sy;
      bit           found, unclear;
      bind_result_t pending[$];
      int           errors;
      int           n_checked;
      int           n_updated, n_review, n_full;

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_TOL:     tol = v[30:0];
            REG_SHIFT_X: sx = v;
            REG_SHIFT_Y: sy = v;
            REG_FOUND:   found = v[0];
            REG_UNCLEAR: unclear = v[0];
            default: ;
         endcase
      endfunction

      function bit near(coord_t a, coord_t b);
         longint d;
         d = longint'(a) - longint'(b);
         if (d < 0) d = -d;
         return d <= longint'(tol);
      endfunction

      function bit line_hit(coord_t l[4]);
         for (int i = 0; i < seg_count; i++) begin
            if (near(l[0], seg_tab[i][0]) && near(l[1], seg_tab[i][1]) &&
                near(l[2], seg_tab[i][2]) && near(l[3], seg_tab[i][3]))
               return 1;
            if (near(l[0], seg_tab[i][2]) && near(l[1], seg_tab[i][3]) &&
                near(l[2], seg_tab[i][0]) && near(l[3], seg_tab[i][1]))
               return 1;
         end
         return 0;
      endfunction

      function coord_t sat_sum(coord_t a, coord_t b);
         longint s;
         s = longint'(a) + longint'(b);
         if (s > 64'sd2147483647) return 32'sh7fffffff;
         if (s < -64'sd2147483648) return 32'sh80000000;
         return coord_t'(s);
      endfunction

      function void note_item(bind_item_t it);
         bind_result_t r;
         coord_t la[4], lb[4];
         r.status = ST_UNCHANGED; r.m1 = 0; r.m2 = 0;
         foreach (r.c[i]) r.c[i] = 0;
         case (it.op)
            OP_CLEAR: begin
               seg_count = 0;
               r.status = ST_LOADED;
            end
            OP_ADD: begin
               if (seg_count < NSLOT) begin
                  for (int i = 0; i < 4; i++) seg_tab[seg_count][i] = it.c[i];
                  seg_count++;
                  r.status = ST_LOADED;
               end else begin
                  r.status = ST_FULL;
               end
            end
            OP_QUERY: begin
               for (int i = 0; i < 4; i++) begin
                  la[i] = it.c[i]; lb[i] = it.c[4+i];
               end
               r.m1 = line_hit(la);
               r.m2 = line_hit(lb);
               if (!r.m1 && !r.m2) r.status = ST_UNCHANGED;
               else if (!found || unclear) r.status = ST_REVIEW;
               else begin
                  r.status = ST_UPDATED;
                  if (r.m1) begin
                     la[0] = sat_sum(la[0], sx); la[1] = sat_sum(la[1], sy);
                     la[2] = sat_sum(la[2], sx); la[3] = sat_sum(la[3], sy);
                  end
                  if (r.m2) begin
                     lb[0] = sat_sum(lb[0], sx); lb[1] = sat_sum(lb[1], sy);
                     lb[2] = sat_sum(lb[2], sx); lb[3] = sat_sum(lb[3], sy);
                  end
               end
               for (int i = 0; i < 4; i++) begin
                  r.c[i] = la[i]; r.c[4+i] = lb[i];
               end
            end
            default: ;
         endcase
         if (r.status == ST_UPDATED) n_updated++;
         if (r.status == ST_REVIEW) n_review++;
         if (r.status == ST_FULL) n_full++;
         pending.push_back(r);
      endfunction

      function void check_result(bind_result_t got);
         bind_result_t exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, got.status);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         n_checked++;
         if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     got.status);
            errors++;
         end
         if (got.m1 !== exp_r.m1 || got.m2 !== exp_r.m2) begin
            $display("%0t: moved flags expected %b%b actual %b%b", $time,
                     exp_r.m1, exp_r.m2, got.m1, got.m2);
            errors++;
         end
         foreach (exp_r.c[i])
            if (got.c[i] !== exp_r.c[i]) begin
               $display("%0t: coord %0d expected %h actual %h", $time, i,
                        exp_r.c[i], got.c[i]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [OP_WIDTH-1:0] req_op = OP_CLEAR;
   coord_t req_c[8];
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic rsp_first_moved, rsp_second_moved;
   coord_t rsp_c[8];
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   binding_scoreboard sb;
   bit   calm;        // no idling in the closing part
   bit   run_done;
   int   stall_cycles;

   initial foreach (req_c[i]) req_c[i] = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   line_match_translate_binding uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_first_x1(req_c[0]), .req_first_y1(req_c[1]),
      .req_first_x2(req_c[2]), .req_first_y2(req_c[3]),
      .req_second_x1(req_c[4]), .req_second_y1(req_c[5]),
      .req_second_x2(req_c[6]), .req_second_y2(req_c[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_first_moved(rsp_first_moved), .rsp_second_moved(rsp_second_moved),
      .rsp_out_first_x1(rsp_c[0]), .rsp_out_first_y1(rsp_c[1]),
      .rsp_out_first_x2(rsp_c[2]), .rsp_out_first_y2(rsp_c[3]),
      .rsp_out_second_x1(rsp_c[4]), .rsp_out_second_y1(rsp_c[5]),
      .rsp_out_second_x2(rsp_c[6]), .rsp_out_second_y2(rsp_c[7]),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // result side: random stall bursts, check on each accepted result
   initial begin
      int gap;
      bind_result_t got;
      sb = new();
      @(posedge clock iff !reset);
      forever begin
         gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.m1 = rsp_first_moved;
            got.m2 = rsp_second_moved;
            foreach (got.c[i]) got.c[i] = rsp_c[i];
            sb.check_result(got);
         end
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          run_done)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WDOG_LIMIT) begin
         $display("line_match_translate_binding regression: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_ADDR_WIDTH'(idx) << 2; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock iff pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic set_motion(logic [30:0] tol, coord_t sx, coord_t sy,
                             bit found, bit unclear);
      csr_write(REG_TOL, {1'b0, tol});
      csr_write(REG_SHIFT_X, sx);
      csr_write(REG_SHIFT_Y, sy);
      csr_write(REG_FOUND, {31'b0, found});
      csr_write(REG_UNCLEAR, {31'b0, unclear});
   endtask

   task automatic send_item(bind_item_t it);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= it.op;
      foreach (req_c[i]) req_c[i] <= it.c[i];
      @(posedge clock iff req_ready);
      sb.note_item(it);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock iff sb.pending.size() == 0);
      repeat (NSLOT + 8) @(posedge clock);
   endtask

   function automatic coord_t rnd_coord();
      case ($urandom_range(0, 4))
         0: return 32'sh7fffffff - coord_t'($urandom_range(0, 3));
         1: return 32'sh80000000 + coord_t'($urandom_range(0, 3));
         2: return coord_t'($urandom_range(0, 2000)) - 1000;
         default: return coord_t'($urandom);
      endcase
   endfunction

   function automatic coord_t jitter(coord_t v, int span);
      return v + coord_t'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic bind_item_t mk(logic [OP_WIDTH-1:0] op);
      bind_item_t it;
      it.op = op;
      foreach (it.c[i]) it.c[i] = rnd_coord();
      return it;
   endfunction

   // query whose lines are near-copies of stored segments (some swapped)
   function automatic bind_item_t mk_hit_query(int span);
      bind_item_t it;
      int k;
      bit sw;
      it = mk(OP_QUERY);
      for (int l = 0; l < 2; l++) begin
         if (sb.seg_count > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, sb.seg_count - 1);
            sw = $urandom_range(0, 1);
            for (int i = 0; i < 4; i++)
               it.c[4*l+i] = jitter(sb.seg_tab[k][sw ? (i + 2) % 4 : i], span);
         end
      end
      return it;
   endfunction

   initial begin
      bind_item_t it;
      int span, nseg;
      run_done = 0;
      calm = 0;
      stall_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: exact match, swapped match, saturation at both ends
      set_motion(31'd0, 32'sh7fffffff, 32'sh80000000, 1, 0);
      it = mk(OP_CLEAR); send_item(it);
      it.op = OP_ADD;
      it.c[0] = 32'sh7fffffff; it.c[1] = 32'sh80000000;
      it.c[2] = 32'sh80000000; it.c[3] = 32'sh7fffffff;
      send_item(it);
      it.c[0] = 0; it.c[1] = -1; it.c[2] = 1; it.c[3] = 32'sh00010000;
      send_item(it);
      it.op = OP_QUERY;
      it.c[4] = 1; it.c[5] = 32'sh00010000; it.c[6] = 0; it.c[7] = -1;
      send_item(it);
      it.c[0] = 32'sh7fffffff; it.c[1] = 32'sh80000000;
      it.c[2] = 32'sh80000000; it.c[3] = 32'sh7fffffff;
      send_item(it);
      it = mk(OP_QUERY); send_item(it);
      it = mk(OP_NONE); send_item(it);
      drain();
      set_motion(31'h7fffffff, 32'sh80000000, 32'sh7fffffff, 1, 1);
      it = mk(OP_QUERY); send_item(it);
      drain();
      set_motion(31'd0, 0, 0, 0, 0);
      it = mk_hit_query(0); send_item(it);
      // fill the table past capacity
      it = mk(OP_CLEAR); send_item(it);
      for (int i = 0; i < NSLOT + 2; i++) begin
         it = mk(OP_ADD); send_item(it);
      end
      it = mk_hit_query(0); send_item(it);
      drain();

      // random phases with fresh register settings
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 10) calm = 1;
         span = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300);
         set_motion(ph % 4 == 3 ? 31'h7fffffff : 31'(span),
                    rnd_coord(), rnd_coord(),
                    $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
         it = mk(OP_CLEAR); send_item(it);
         nseg = ph == 5 ? NSLOT + 3 : $urandom_range(1, 12);
         for (int i = 0; i < nseg; i++) begin
            it = mk(OP_ADD);
            if (i > 0 && i - 1 < sb.seg_count && $urandom_range(0, 2) == 0)
               foreach (it.c[j]) it.c[j] = jitter(sb.seg_tab[i - 1][j % 4], 500);
            send_item(it);
         end
         for (int i = 0; i < NRAND / 12 - nseg; i++) begin
            case ($urandom_range(0, 19))
               0: it = mk(OP_NONE);
               1: it = mk(OP_ADD);
               2: it = mk(OP_QUERY);
               default: it = mk_hit_query(span + $urandom_range(0, 1));
            endcase
            send_item(it);
         end
         drain();
      end

      run_done = 1;
      $display("covered %0d results: %0d updated, %0d review, %0d table-full",
               sb.n_checked, sb.n_updated, sb.n_review, sb.n_full);
      $display("twelve random register phases incl. full table and swapped-end hits");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("line_match_translate_binding regression: pass");
      else
         $display("line_match_translate_binding regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/lmtb_pkg.sv
src/lmtb_cell.sv
src/line_match_translate_binding.sv
test/tb_line_match_translate_binding.sv
